// ===== rtl/hepd_pkg.sv =====
// ----------------------------------------------------------------------------
// hepd_pkg
// Shared types and constants for the palette decoder.
// ----------------------------------------------------------------------------
package hepd_pkg;

    localparam int COLOR_W    = 32;
    localparam int PIXEL_W    = 8;
    localparam int COUNT_W    = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [1:0] {
        MODE_PLAIN = 2'd0,
        MODE_EHB   = 2'd1,
        MODE_HAM   = 2'd2
    } mode_t;

    localparam logic [CFG_IDX_W-1:0] CFG_DECODE_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PALETTE_COUNT = 2'd1;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_PIXEL = 1'b1;

    localparam logic [1:0] HAM_LOAD  = 2'd0;
    localparam logic [1:0] HAM_RED   = 2'd1;
    localparam logic [1:0] HAM_GREEN = 2'd2;
    localparam logic [1:0] HAM_BLUE  = 2'd3;

    localparam logic [1:0]         MODE_RESET      = 2'd0;
    localparam logic [COUNT_W-1:0] COUNT_RESET     = 9'd32;
    localparam logic [COUNT_W-1:0] EHB_OFFSET      = 9'd32;
    localparam logic [COLOR_W-1:0] EHB_ALPHA       = 32'hFF00_0000;
    localparam logic [COLOR_W-1:0] EHB_MASK        = 32'hFF7F_7F7F;

    typedef struct packed {
        logic       ham;
        logic       half;
        logic       err;
        logic [1:0] ctl;
        logic [3:0] nib;
    } pix_ctl_t;

endpackage

// ===== rtl/hepd_if.sv =====
// ----------------------------------------------------------------------------
// hepd_if
// Valid/ready channel interfaces for requests, results and configuration.
// ----------------------------------------------------------------------------
interface hepd_req_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [7:0]  pixel_value;
    logic [31:0] entry_data;

    modport source (output valid, output cmd, output pixel_value, output entry_data,
                    input ready);
    modport sink   (input valid, input cmd, input pixel_value, input entry_data,
                    output ready);
endinterface

interface hepd_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] color;
    logic        index_error;

    modport source (output valid, output color, output index_error, input ready);
    modport sink   (input valid, input color, input index_error, output ready);
endinterface

interface hepd_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/ham_ehb_palette_decode.sv =====
// ----------------------------------------------------------------------------
// ham_ehb_palette_decode
// Palette decoder for plain, extra-half-brite and hold-and-modify pixels.
//
// The req channel carries items: a write item (cmd 0) stores entry_data in
// palette slot pixel_value and gives no result; a pixel item (cmd 1) gives
// one result item on the rsp channel with the color and an index error flag.
// The cfg channel writes the decode mode (index 0) and the palette count
// (index 1); it is always ready. It must be written only while the block
// is idle; the block does not enforce this. A pixel item is read from the
// palette memory as it is accepted; its result is then registered and
// shown on rsp. One item is taken per cycle while rsp is not stalled;
// the palette read and the held-color merge in the next stage set that rate.
// Reset clears the held color, sets the mode to plain and the count to 32.
// The palette itself is not cleared and must be written before it is read.
// When the receiver stalls, the result register and the stage before it hold
// their items and req.ready falls only when both are full.
// ----------------------------------------------------------------------------
module ham_ehb_palette_decode #(
    parameter int PALETTE_DEPTH = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    hepd_req_if.sink   req,
    hepd_rsp_if.source rsp,
    hepd_cfg_if.sink   cfg
);
    import hepd_pkg::*;

    localparam int AW = $clog2(PALETTE_DEPTH);

    logic [1:0]         mode;
    logic [COUNT_W-1:0] count;
    logic               s1_take;
    logic               s1_valid;
    pix_ctl_t           s1_ctl;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [31:0]        wr_data;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic [31:0]        rd_data;

    hepd_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .mode  (mode),
        .count (count)
    );

    hepd_front #(
        .DEPTH (PALETTE_DEPTH),
        .AW    (AW)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .mode     (mode),
        .count    (count),
        .s1_take  (s1_take),
        .s1_valid (s1_valid),
        .s1_ctl   (s1_ctl),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr)
    );

    hepd_palette_ram #(
        .DEPTH (PALETTE_DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    hepd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .s1_valid (s1_valid),
        .s1_ctl   (s1_ctl),
        .rd_data  (rd_data),
        .s1_take  (s1_take),
        .rsp      (rsp)
    );
endmodule

// ===== rtl/hepd_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// hepd_cfg_regs
// Decode mode and palette count registers behind the configuration channel.
// ----------------------------------------------------------------------------
module hepd_cfg_regs (
    input  logic                    clk,
    input  logic                    rst_n,
    hepd_cfg_if.sink                cfg,
    output logic [1:0]              mode,
    output logic [8:0]              count
);
    import hepd_pkg::*;

    logic [1:0]         mode_reg;
    logic [1:0]         mode_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        mode_next  = mode_reg;
        count_next = count_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_DECODE_MODE:   mode_next  = cfg.data[1:0];
                CFG_PALETTE_COUNT: count_next = cfg.data[COUNT_W-1:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_RESET;
            count_reg <= COUNT_RESET;
        end
        else
        begin
            mode_reg  <= mode_next;
            count_reg <= count_next;
        end
    end

    assign mode  = mode_reg;
    assign count = count_reg;
endmodule

// ===== rtl/hepd_palette_ram.sv =====
// ----------------------------------------------------------------------------
// hepd_palette_ram
// Palette store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module hepd_palette_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [31:0]   wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [31:0]   rd_data
);
    logic [31:0] mem [DEPTH];
    logic [31:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

// ===== rtl/hepd_front.sv =====
// ----------------------------------------------------------------------------
// hepd_front
// Accepts items, stores palette writes and issues the palette read for pixels.
// ----------------------------------------------------------------------------
module hepd_front #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    hepd_req_if.sink              req,
    input  logic [1:0]            mode,
    input  logic [8:0]            count,
    input  logic                  s1_take,
    output logic                  s1_valid,
    output hepd_pkg::pix_ctl_t    s1_ctl,
    output logic                  wr_en,
    output logic [AW-1:0]         wr_addr,
    output logic [31:0]           wr_data,
    output logic                  rd_en,
    output logic [AW-1:0]         rd_addr
);
    import hepd_pkg::*;

    localparam logic [COUNT_W-1:0] DEPTH_C = COUNT_W'(DEPTH);

    logic               accept;
    logic [COUNT_W-1:0] v9;
    logic [COUNT_W-1:0] vc;
    logic [COUNT_W-1:0] v_minus;
    logic [COUNT_W-1:0] addr9;
    logic               in_range;
    logic               half_ok;
    pix_ctl_t           ctl;
    logic               s1_valid_reg;
    logic               s1_valid_next;
    pix_ctl_t           s1_ctl_reg;

    assign req.ready = !s1_valid_reg || s1_take;
    assign accept    = req.valid && req.ready;

    assign v9       = {1'b0, req.pixel_value};
    assign vc       = (count > DEPTH_C) ? DEPTH_C : count;
    assign v_minus  = v9 - EHB_OFFSET;
    assign in_range = v9 < vc;
    assign half_ok  = (v9 >= EHB_OFFSET) && (v_minus < vc);

    always_comb
    begin
        ctl      = '0;
        ctl.ctl  = req.pixel_value[5:4];
        ctl.nib  = req.pixel_value[3:0];
        addr9    = v9;
        unique case (mode)
            MODE_HAM:
            begin
                ctl.ham = 1'b1;
                ctl.err = (req.pixel_value[7:6] != 2'd0)
                          || ((req.pixel_value[5:4] == HAM_LOAD) && !in_range);
            end
            MODE_EHB:
            begin
                if (in_range)
                begin
                    ctl.err = 1'b0;
                end
                else if (half_ok)
                begin
                    ctl.half = 1'b1;
                    addr9    = v_minus;
                end
                else
                begin
                    ctl.err = 1'b1;
                end
            end
            default:
            begin
                ctl.err = !in_range;
            end
        endcase
    end

    assign wr_en   = accept && (req.cmd == CMD_WRITE) && (v9 < DEPTH_C);
    assign wr_addr = v9[AW-1:0];
    assign wr_data = req.entry_data;
    assign rd_en   = accept && (req.cmd == CMD_PIXEL);
    assign rd_addr = addr9[AW-1:0];

    always_comb
    begin
        if (rd_en)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_take)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            s1_ctl_reg <= ctl;
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1_ctl   = s1_ctl_reg;
endmodule

// ===== rtl/hepd_back.sv =====
// ----------------------------------------------------------------------------
// hepd_back
// Forms the color from palette data, updates the held color, drives results.
// ----------------------------------------------------------------------------
module hepd_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s1_valid,
    input  hepd_pkg::pix_ctl_t    s1_ctl,
    input  logic [31:0]           rd_data,
    output logic                  s1_take,
    hepd_rsp_if.source            rsp
);
    import hepd_pkg::*;

    logic               move;
    logic [7:0]         nib8;
    logic [COLOR_W-1:0] held_reg;
    logic [COLOR_W-1:0] held_next;
    logic [COLOR_W-1:0] color_c;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [COLOR_W-1:0] color_reg;
    logic               err_reg;

    assign s1_take = !out_valid_reg || rsp.ready;
    assign move    = s1_valid && s1_take;
    assign nib8    = {s1_ctl.nib, s1_ctl.nib};

    always_comb
    begin
        held_next = held_reg;
        if (s1_ctl.ham && !s1_ctl.err)
        begin
            case (s1_ctl.ctl)
                HAM_LOAD:  held_next = rd_data;
                HAM_RED:   held_next = {held_reg[31:8], nib8};
                HAM_GREEN: held_next = {held_reg[31:16], nib8, held_reg[7:0]};
                HAM_BLUE:  held_next = {held_reg[31:24], nib8, held_reg[15:0]};
                default:   held_next = held_reg;
            endcase
        end
    end

    always_comb
    begin
        if (s1_ctl.ham)
        begin
            color_c = held_next;
        end
        else if (s1_ctl.err)
        begin
            color_c = '0;
        end
        else if (s1_ctl.half)
        begin
            color_c = ((rd_data >> 1) | EHB_ALPHA) & EHB_MASK;
        end
        else
        begin
            color_c = rd_data;
        end
    end

    always_comb
    begin
        if (move)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            held_reg      <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (move)
            begin
                held_reg <= held_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (move)
        begin
            color_reg <= color_c;
            err_reg   <= s1_ctl.err;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.color       = color_reg;
    assign rsp.index_error = err_reg;
endmodule

// ===== bench/tb_ham_ehb_palette_decode.sv =====
// ----------------------------------------------------------------------------
// tb_ham_ehb_palette_decode
// Self-checking bench for the palette decoder. The bench loads the whole
// palette, runs a directed set of pixels through each decode mode, and then
// runs random phases under many mode and count settings. Both channel sides
// insert random gaps. Each result item is checked against the bench's own
// model of the palette, the held color and the registers.
// ----------------------------------------------------------------------------
module tb_ham_ehb_palette_decode;

    import hepd_pkg::*;

    localparam int          CLK_PERIOD   = 20;
    localparam int          DEPTH        = 256;
    localparam longint      LIMIT_CYCLES = 1_000_000;
    localparam logic [1:0]  MODE_UNUSED  = 2'd3;
    localparam logic [1:0]  CFG_SPARE_LO = 2'd2;
    localparam logic [1:0]  CFG_SPARE_HI = 2'd3;

    typedef struct packed {
        logic        cmd;
        logic [7:0]  pixel_value;
        logic [31:0] entry_data;
    } req_item_t;

    typedef struct packed {
        logic [31:0] color;
        logic        index_error;
    } pixel_result_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    hepd_req_if req_ch ();
    hepd_rsp_if rsp_ch ();
    hepd_cfg_if cfg_ch ();

    ham_ehb_palette_decode #(
        .PALETTE_DEPTH(DEPTH)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    req_item_t     pending_items[$];
    pixel_result_t color_expect[$];

    logic [31:0]   pal_model [DEPTH];
    logic [31:0]   held_color = '0;
    logic [1:0]    cur_mode   = MODE_RESET;
    logic [8:0]    pal_count  = COUNT_RESET;

    int unsigned   items_queued   = 0;
    int unsigned   accepted_items = 0;
    int unsigned   fail_count     = 0;
    int unsigned   send_pause     = 0;
    int unsigned   stall_left     = 0;
    bit            gaps_on        = 1'b1;

    always
    begin
        clk = 1'b0;
        #(CLK_PERIOD / 2);
        clk = 1'b1;
        #(CLK_PERIOD / 2);
    end

    function automatic int unsigned pick_pause();
        int unsigned r;
        if (!gaps_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic pixel_result_t predict_pixel(input logic [7:0] v);
        pixel_result_t res;
        logic [8:0]    lim;
        logic [8:0]    idx;
        logic [7:0]    nib8;
        lim  = (pal_count > 9'(DEPTH)) ? 9'(DEPTH) : pal_count;
        idx  = {1'b0, v} - EHB_OFFSET;
        nib8 = {v[3:0], v[3:0]};
        res  = '0;
        if (cur_mode == MODE_HAM)
        begin
            if (v[7:6] != 2'b00)
                res.index_error = 1'b1;
            else
            begin
                case (v[5:4])
                    HAM_LOAD:
                    begin
                        if ({1'b0, v} < lim)
                            held_color = pal_model[v];
                        else
                            res.index_error = 1'b1;
                    end
                    HAM_RED:   held_color[7:0]   = nib8;
                    HAM_GREEN: held_color[15:8]  = nib8;
                    default:   held_color[23:16] = nib8;
                endcase
            end
            res.color = held_color;
        end
        else if (cur_mode == MODE_EHB)
        begin
            if ({1'b0, v} < lim)
                res.color = pal_model[v];
            else if ({1'b0, v} >= EHB_OFFSET && idx < lim)
                res.color = ((pal_model[idx[7:0]] >> 1) | EHB_ALPHA) & EHB_MASK;
            else
                res.index_error = 1'b1;
        end
        else
        begin
            if ({1'b0, v} < lim)
                res.color = pal_model[v];
            else
                res.index_error = 1'b1;
        end
        return res;
    endfunction

    function automatic logic [7:0] pick_pixel(input logic [1:0] mode, input int unsigned lim);
        int unsigned r;
        int unsigned top;
        int unsigned pick;
        r = $urandom_range(0, 99);
        if (mode == MODE_HAM)
            pick = (r < 88) ? $urandom_range(0, 63) : $urandom_range(64, 255);
        else if (lim != 0 && r < 40)
            pick = $urandom_range(0, lim - 1);
        else if (mode == MODE_EHB && r < 80)
        begin
            top  = (lim + 31 > 255) ? 255 : lim + 31;
            pick = $urandom_range(32, top);
        end
        else
            pick = $urandom_range(0, 255);
        return pick[7:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : req_driver
        req_item_t nxt;
        if (!rst_n)
        begin
            req_ch.valid       <= 1'b0;
            req_ch.cmd         <= CMD_WRITE;
            req_ch.pixel_value <= '0;
            req_ch.entry_data  <= '0;
            send_pause         <= 0;
        end
        else if (!req_ch.valid || req_ch.ready)
        begin
            if (send_pause != 0)
            begin
                send_pause   <= send_pause - 1;
                req_ch.valid <= 1'b0;
            end
            else if (pending_items.size() != 0)
            begin
                nxt                 = pending_items.pop_front();
                req_ch.valid       <= 1'b1;
                req_ch.cmd         <= nxt.cmd;
                req_ch.pixel_value <= nxt.pixel_value;
                req_ch.entry_data  <= nxt.entry_data;
                send_pause         <= pick_pause();
            end
            else
                req_ch.valid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            stall_left   <= 0;
        end
        else if (stall_left != 0)
        begin
            rsp_ch.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end
        else
        begin
            rsp_ch.ready <= 1'b1;
            stall_left   <= pick_pause();
        end
    end

    always @(posedge clk)
    begin : result_monitor
        pixel_result_t want;
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (color_expect.size() == 0)
                begin
                    $error("unexpected result item: color %h, index_error %b",
                           rsp_ch.color, rsp_ch.index_error);
                    fail_count++;
                end
                else
                begin
                    want = color_expect.pop_front();
                    if (rsp_ch.color !== want.color)
                    begin
                        $error("color mismatch: expected %h, actual %h",
                               want.color, rsp_ch.color);
                        fail_count++;
                    end
                    if (rsp_ch.index_error !== want.index_error)
                    begin
                        $error("index_error mismatch: expected %b, actual %b",
                               want.index_error, rsp_ch.index_error);
                        fail_count++;
                    end
                end
            end
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                case (cfg_ch.index)
                    CFG_DECODE_MODE:   cur_mode  = cfg_ch.data[1:0];
                    CFG_PALETTE_COUNT: pal_count = cfg_ch.data[8:0];
                    default: ;
                endcase
            end
            if (req_ch.valid && req_ch.ready)
            begin
                accepted_items++;
                if (req_ch.cmd == CMD_WRITE)
                    pal_model[req_ch.pixel_value] = req_ch.entry_data;
                else
                    color_expect.push_back(predict_pixel(req_ch.pixel_value));
            end
        end
    end

    task automatic queue_write(input logic [7:0] slot, input logic [31:0] data);
        pending_items.push_back('{CMD_WRITE, slot, data});
        items_queued++;
    endtask

    task automatic queue_pixel(input logic [7:0] v);
        pending_items.push_back('{CMD_PIXEL, v, $urandom()});
        items_queued++;
    endtask

    task automatic wait_idle(input int unsigned settle);
        while (items_queued != accepted_items || color_expect.size() != 0)
            @(negedge clk);
        repeat (settle) @(negedge clk);
    endtask

    task automatic cfg_handshake();
        do
            @(posedge clk);
        while (!cfg_ch.ready);
    endtask

    task automatic set_config(input logic [1:0] mode, input logic [8:0] count,
                              input bit spare);
        logic [31:0] word;
        @(posedge clk);
        word = $urandom();
        if ($urandom_range(0, 1) == 0)
            word[31:2] = '0;
        word[1:0] = mode;
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= CFG_DECODE_MODE;
        cfg_ch.data  <= word;
        cfg_handshake();
        word = $urandom();
        if ($urandom_range(0, 1) == 0)
            word[31:9] = '0;
        word[8:0] = count;
        cfg_ch.index <= CFG_PALETTE_COUNT;
        cfg_ch.data  <= word;
        cfg_handshake();
        if (spare)
        begin
            cfg_ch.index <= ($urandom_range(0, 1) == 0) ? CFG_SPARE_LO : CFG_SPARE_HI;
            cfg_ch.data  <= $urandom();
            cfg_handshake();
        end
        cfg_ch.valid <= 1'b0;
    endtask

    initial
    begin : stimulus
        logic [1:0]  mode_plan [14];
        logic [8:0]  count_plan [14];
        int unsigned lim;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.index       <= CFG_DECODE_MODE;
        cfg_ch.data        <= '0;
        rst_n              <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        queue_write(8'd0, 32'h0000_0000);
        queue_write(8'd1, 32'hFFFF_FFFF);
        for (int s = 2; s < DEPTH; s++)
            queue_write(s[7:0], $urandom());

        // Plain mode at the reset count, including indices past the count.
        queue_pixel(8'd0);
        queue_pixel(8'd31);
        queue_pixel(8'd32);
        queue_pixel(8'd255);

        // Half-brite: upper entries map to halved copies of the low ones.
        wait_idle(4);
        set_config(MODE_EHB, 9'd32, 1'b1);
        queue_pixel(8'd0);
        queue_pixel(8'd32);
        queue_pixel(8'd33);
        queue_pixel(8'd63);
        queue_pixel(8'd64);
        queue_pixel(8'd255);
        wait_idle(4);
        set_config(MODE_EHB, 9'd16, 1'b0);
        queue_pixel(8'd20);
        queue_pixel(8'd40);
        queue_pixel(8'd48);

        // Hold and modify: start from the reset held color, then load and patch.
        wait_idle(4);
        set_config(MODE_HAM, 9'd16, 1'b0);
        queue_pixel(8'h3A);
        queue_pixel(8'h01);
        queue_pixel(8'h10);
        queue_pixel(8'h2F);
        queue_pixel(8'h35);
        queue_pixel(8'h0F);
        queue_pixel(8'h40);
        queue_pixel(8'hFF);
        wait_idle(4);
        set_config(MODE_HAM, 9'd8, 1'b0);
        queue_pixel(8'h0C);
        queue_pixel(8'h3F);

        // The unused mode code decodes as plain; a zero count rejects everything.
        wait_idle(4);
        set_config(MODE_UNUSED, 9'd256, 1'b0);
        queue_pixel(8'd255);
        queue_pixel(8'd0);
        wait_idle(4);
        set_config(MODE_PLAIN, 9'd0, 1'b0);
        queue_pixel(8'd0);

        mode_plan  = '{MODE_PLAIN, MODE_EHB, MODE_HAM, MODE_HAM, MODE_EHB, MODE_PLAIN,
                       MODE_HAM, MODE_UNUSED, MODE_EHB, MODE_HAM, MODE_PLAIN, MODE_HAM,
                       MODE_EHB, MODE_UNUSED};
        count_plan = '{9'd0, 9'd1, 9'd15, 9'd16, 9'd33, 9'd32, 9'd63, 9'd64,
                       9'd255, 9'd256, 9'd511, 9'd257, 9'd128, 9'd0};
        count_plan[13] = 9'($urandom_range(0, 511));

        for (int p = 0; p < 14; p++)
        begin
            wait_idle(4);
            gaps_on = (p % 3) != 1;
            set_config(mode_plan[p], count_plan[p], $urandom_range(0, 2) == 0);
            lim = (count_plan[p] > DEPTH) ? DEPTH : count_plan[p];
            for (int i = 0; i < 100; i++)
            begin
                if ($urandom_range(0, 99) < 12)
                    queue_write(8'($urandom_range(0, 255)), $urandom());
                else
                    queue_pixel(pick_pixel(mode_plan[p], lim));
            end
        end

        wait_idle(8);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/hepd_pkg.sv
rtl/hepd_if.sv
rtl/hepd_cfg_regs.sv
rtl/hepd_palette_ram.sv
rtl/hepd_front.sv
rtl/hepd_back.sv
rtl/ham_ehb_palette_decode.sv
bench/tb_ham_ehb_palette_decode.sv
